>>> sv/tpq_pkg.sv
// Package for the triage priority queue: field widths, request and response
// structs, op and status codes, default sizes. No dependencies.
`timescale 1ns / 1ps

package tpq_pkg;

  // Field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned PRIO_W = 4;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned LVL_W  = 5;

  // Default sizes
  localparam int unsigned ID_SPACE_DEF    = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Op codes
  localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
  localparam logic [OP_W-1:0] OP_ENQUEUE    = 3'd2;
  localparam logic [OP_W-1:0] OP_TREAT      = 3'd3;
  localparam logic [OP_W-1:0] OP_POP        = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [ST_W-1:0] ST_DUPLICATE   = 3'd2;
  localparam logic [ST_W-1:0] ST_QUEUE_EMPTY = 3'd3;
  localparam logic [ST_W-1:0] ST_STACK_EMPTY = 3'd4;
  localparam logic [ST_W-1:0] ST_QUEUE_FULL  = 3'd5;
  localparam logic [ST_W-1:0] ST_STACK_FULL  = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   patient_id;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_priority;
    logic              recorded;
    logic [LVL_W-1:0]  queue_level;
    logic [LVL_W-1:0]  stack_level;
  } rsp_t;

  // One service queue entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } qent_t;

endpackage

>>> sv/triage_priority_queue_with_stack.sv
// Triage priority queue top level: id registry, sorted service queue and
// treated stack, run by a small sequencer. Depends on tpq_pkg.
`timescale 1ns / 1ps

// One request is one operation and yields exactly one response. The block
// takes a request when it is idle and no response is parked behind a full
// output register; the response lands in the output register and may wait
// there while the next request is already taken. Register, unregister, treat,
// pop, a refused enqueue and an enqueue into an empty queue finish in the
// execute state. An enqueue into a non-empty queue then walks back from the
// tail through the queue memory, comparing and moving one entry per cycle
// past every waiting entry with a larger priority value, and then writes the
// new entry into the gap. The queue is a circular buffer, so treat pops in one step.
// Smaller priority values are served first; equal values first in, first out.
module triage_priority_queue_with_stack #(
  parameter int unsigned ID_SPACE    = tpq_pkg::ID_SPACE_DEF,
  parameter int unsigned QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = tpq_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  tpq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output tpq_pkg::rsp_t rsp_o
);

  // Registry only needs the ids the 8-bit field can carry
  localparam int unsigned REG_DEPTH = (ID_SPACE < (1 << tpq_pkg::ID_W)) ?
                                      ID_SPACE : (1 << tpq_pkg::ID_W);
  localparam int unsigned REG_AW = $clog2(REG_DEPTH);
  localparam int unsigned QAW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SAW    = $clog2(STACK_DEPTH);
  localparam int unsigned SFW    = $clog2(STACK_DEPTH + 1);

  localparam logic [16:0]  ID_LIM     = 17'(ID_SPACE);
  localparam logic [QAW:0] QSUM_DEPTH = (QAW + 1)'(QUEUE_DEPTH);
  localparam logic [QFW-1:0] QFULL    = QFW'(QUEUE_DEPTH);
  localparam logic [SFW-1:0] SFULL    = SFW'(STACK_DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  logic [1:0] state_q, state_d;

  // Latched request
  logic [tpq_pkg::OP_W-1:0]   op_q;
  logic [tpq_pkg::ID_W-1:0]   id_q;
  logic [tpq_pkg::PRIO_W-1:0] pr_q;

  // Pointers and fills
  logic [QAW-1:0] head_q, head_d;
  logic [QFW-1:0] qfill_q, qfill_d;
  logic [QFW-1:0] pos_q, pos_d;
  logic [SFW-1:0] sfill_q, sfill_d;

  // Registry
  logic [REG_DEPTH-1:0]       valid_q;
  logic [tpq_pkg::PRIO_W-1:0] prio_mem [REG_DEPTH];
  logic [tpq_pkg::PRIO_W-1:0] prio_rd_q;
  logic                       set_v, clr_v, pwr_en;

  // Queue memory, one read and one write port
  tpq_pkg::qent_t qmem [QUEUE_DEPTH];
  tpq_pkg::qent_t qrd_q, qwr_data, new_ent;
  logic [QAW-1:0] qrd_addr, qwr_addr;
  logic           qrd_en, qwr_en;

  // Stack memory
  logic [tpq_pkg::ID_W-1:0] smem [STACK_DEPTH];
  logic [tpq_pkg::ID_W-1:0] srd_q;
  logic [SAW-1:0]           s_rd_addr;
  logic [SFW-1:0]           sdec;
  logic                     swr_en;

  // Response path
  tpq_pkg::rsp_t res_d, out_q, pend_res_q;
  logic          rsp_valid_q, pend_q, fin, out_free, accept;

  // Lookups
  logic                   in_space, reg_hit, f_hit;
  logic [REG_AW-1:0]      rid, fidx;

  // Circular slot to physical address; sum stays below twice the depth
  function automatic logic [QAW-1:0] qaddr(input logic [QAW-1:0] head,
                                           input logic [QFW-1:0] slot);
    logic [QAW:0] sum;
    sum = {1'b0, head} + (QAW + 1)'(slot);
    if (sum >= QSUM_DEPTH) begin
      sum = sum - QSUM_DEPTH;
    end
    return sum[QAW-1:0];
  endfunction

  assign req_ready_o = (state_q == S_IDLE) && !pend_q;
  assign accept      = req_valid_i && req_ready_o;
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = out_q;

  assign in_space = {9'd0, id_q} < ID_LIM;
  assign rid      = id_q[REG_AW-1:0];
  assign reg_hit  = in_space && valid_q[rid];
  assign fidx     = qrd_q.id[REG_AW-1:0];
  assign f_hit    = ({9'd0, qrd_q.id} < ID_LIM) && valid_q[fidx];
  assign new_ent  = '{id: id_q, prio: prio_rd_q};

  assign sdec      = sfill_q - SFW'(1);
  assign s_rd_addr = (sfill_q == '0) ? '0 : sdec[SAW-1:0];

  // Sequencer and result
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    qfill_d  = qfill_q;
    pos_d    = pos_q;
    sfill_d  = sfill_q;
    set_v    = 1'b0;
    clr_v    = 1'b0;
    pwr_en   = 1'b0;
    qrd_en   = 1'b0;
    qrd_addr = head_q;
    qwr_en   = 1'b0;
    qwr_addr = head_q;
    qwr_data = new_ent;
    swr_en   = 1'b0;
    fin      = 1'b0;
    res_d    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          qrd_en  = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        fin = 1'b1;
        unique case (op_q)
          tpq_pkg::OP_REGISTER: begin
            if (!in_space) begin
              res_d.status = tpq_pkg::ST_NOT_FOUND;
            end else if (valid_q[rid]) begin
              res_d.status = tpq_pkg::ST_DUPLICATE;
            end else begin
              set_v  = 1'b1;
              pwr_en = 1'b1;
            end
          end
          tpq_pkg::OP_UNREGISTER: begin
            if (!reg_hit) begin
              res_d.status = tpq_pkg::ST_NOT_FOUND;
            end else begin
              clr_v = 1'b1;
            end
          end
          tpq_pkg::OP_ENQUEUE: begin
            if (!reg_hit) begin
              res_d.status = tpq_pkg::ST_NOT_FOUND;
            end else if (qfill_q == QFULL) begin
              res_d.status = tpq_pkg::ST_QUEUE_FULL;
            end else if (qfill_q == '0) begin
              qwr_en   = 1'b1;
              qwr_addr = head_q;
              qfill_d  = qfill_q + QFW'(1);
            end else begin
              // start the walk at the tail
              fin      = 1'b0;
              pos_d    = qfill_q;
              qrd_en   = 1'b1;
              qrd_addr = qaddr(head_q, qfill_q - QFW'(1));
              state_d  = S_INS;
            end
          end
          tpq_pkg::OP_TREAT: begin
            if (qfill_q == '0) begin
              res_d.status = tpq_pkg::ST_QUEUE_EMPTY;
            end else begin
              head_d             = qaddr(head_q, QFW'(1));
              qfill_d            = qfill_q - QFW'(1);
              res_d.out_id       = qrd_q.id;
              res_d.out_priority = qrd_q.prio;
              if (f_hit) begin
                if (sfill_q == SFULL) begin
                  res_d.status = tpq_pkg::ST_STACK_FULL;
                end else begin
                  swr_en         = 1'b1;
                  sfill_d        = sfill_q + SFW'(1);
                  res_d.recorded = 1'b1;
                end
              end
            end
          end
          tpq_pkg::OP_POP: begin
            if (sfill_q == '0) begin
              res_d.status = tpq_pkg::ST_STACK_EMPTY;
            end else begin
              sfill_d      = sdec;
              res_d.out_id = srd_q;
            end
          end
          default: begin
          end
        endcase
        if (fin) begin
          state_d = S_IDLE;
        end
      end
      S_INS: begin
        // qrd_q holds the entry at slot pos-1
        qwr_en   = 1'b1;
        qwr_addr = qaddr(head_q, pos_q);
        if (qrd_q.prio > prio_rd_q) begin
          qwr_data = qrd_q;
          pos_d    = pos_q - QFW'(1);
          if (pos_q == QFW'(1)) begin
            state_d = S_PUT;
          end else begin
            qrd_en   = 1'b1;
            qrd_addr = qaddr(head_q, pos_q - QFW'(2));
          end
        end else begin
          qfill_d = qfill_q + QFW'(1);
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PUT: begin
        qwr_en   = 1'b1;
        qwr_addr = qaddr(head_q, pos_q);
        qfill_d  = qfill_q + QFW'(1);
        fin      = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.queue_level = tpq_pkg::LVL_W'(qfill_d);
    res_d.stack_level = tpq_pkg::LVL_W'(sfill_d);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      qfill_q <= '0;
      pos_q   <= '0;
      sfill_q <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      qfill_q <= qfill_d;
      pos_q   <= pos_d;
      sfill_q <= sfill_d;
      if (set_v) begin
        valid_q[rid] <= 1'b1;
      end
      if (clr_v) begin
        valid_q[rid] <= 1'b0;
      end
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.op;
      id_q <= req_i.patient_id;
      pr_q <= req_i.priority_req;
    end
  end

  // Registry priority memory
  always_ff @(posedge clk_i) begin
    if (pwr_en) begin
      prio_mem[rid] <= pr_q;
    end
    if (accept) begin
      prio_rd_q <= prio_mem[req_i.patient_id[REG_AW-1:0]];
    end
  end

  // Queue memory
  always_ff @(posedge clk_i) begin
    if (qwr_en) begin
      qmem[qwr_addr] <= qwr_data;
    end
    if (qrd_en) begin
      qrd_q <= qmem[qrd_addr];
    end
  end

  // Stack memory
  always_ff @(posedge clk_i) begin
    if (swr_en) begin
      smem[sfill_q[SAW-1:0]] <= qrd_q.id;
    end
    if (accept) begin
      srd_q <= smem[s_rd_addr];
    end
  end

  // Output register plus one parked response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (pend_q && out_free) begin
        rsp_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (fin) begin
        if (out_free) begin
          rsp_valid_q <= 1'b1;
        end else begin
          pend_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      out_q <= pend_res_q;
    end else if (fin) begin
      if (out_free) begin
        out_q <= res_d;
      end else begin
        pend_res_q <= res_d;
      end
    end
  end

endmodule
